@@ src/ehp_pkg.sv @@
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types and constants for the Ethernet / IPv4 / TCP-UDP header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

  // largest frame length that is still reported normally
  localparam logic [15:0] MAX_CAPTURE = 16'd1600;

  // header geometry
  localparam logic [15:0] ETH_LEN     = 16'd14;
  localparam logic [16:0] IP_MIN_END  = 17'd34;   // ethernet plus minimal ip header
  localparam logic [16:0] TCP_MIN     = 17'd20;
  localparam logic [16:0] UDP_LEN     = 17'd8;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  // byte offsets of fixed fields within the frame
  localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
  localparam logic [15:0] OFF_IHL      = 16'd14;
  localparam logic [15:0] OFF_TOT_HI   = 16'd16;
  localparam logic [15:0] OFF_TOT_LO   = 16'd17;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFF_SRC0     = 16'd26;
  localparam logic [15:0] OFF_SRC1     = 16'd27;
  localparam logic [15:0] OFF_SRC2     = 16'd28;
  localparam logic [15:0] OFF_SRC3     = 16'd29;
  localparam logic [15:0] OFF_DST0     = 16'd30;
  localparam logic [15:0] OFF_DST1     = 16'd31;
  localparam logic [15:0] OFF_DST2     = 16'd32;
  localparam logic [15:0] OFF_DST3     = 16'd33;

  // byte offsets within the transport header
  localparam logic [3:0] L4_SPORT_HI = 4'd0;
  localparam logic [3:0] L4_SPORT_LO = 4'd1;
  localparam logic [3:0] L4_DPORT_HI = 4'd2;
  localparam logic [3:0] L4_DPORT_LO = 4'd3;
  localparam logic [3:0] L4_ULEN_HI  = 4'd4;
  localparam logic [3:0] L4_ULEN_LO  = 4'd5;
  localparam logic [3:0] L4_ACK0     = 4'd8;
  localparam logic [3:0] L4_ACK1     = 4'd9;
  localparam logic [3:0] L4_ACK2     = 4'd10;
  localparam logic [3:0] L4_ACK3     = 4'd11;
  localparam logic [3:0] L4_DOFF     = 4'd12;
  localparam logic [3:0] L4_FLAGS    = 4'd13;
  localparam logic [15:0] L4_SPAN    = 16'd14;

  // packet classes
  typedef enum logic [3:0] {
    CLS_RUNT      = 4'd0,
    CLS_NON_IP    = 4'd1,
    CLS_IP_SHORT  = 4'd2,
    CLS_IP_OTHER  = 4'd3,
    CLS_TCP_SHORT = 4'd4,
    CLS_TCP       = 4'd5,
    CLS_UDP_SHORT = 4'd6,
    CLS_UDP       = 4'd7,
    CLS_TOO_BIG   = 4'd8
  } ehp_class_t;

  // raw header fields picked off the byte stream
  typedef struct packed {
    logic [15:0] ethertype;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_len;
    logic [31:0] ack_num;
    logic [3:0]  doff;
    logic        ack_flag;
  } ehp_hdr_t;

  // one finished frame as handed from front to back
  typedef struct packed {
    logic [15:0] cap_len;
    logic        oversize;
    ehp_hdr_t    hdr;
  } ehp_rec_t;

endpackage

@@ src/ehp_if.sv @@
// ----------------------------------------------------------------------------
// ehp_in_if / ehp_out_if
// Valid/ready stream channels for frame bytes and parse results.
// ----------------------------------------------------------------------------
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehp_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        cap_len;
  logic [3:0]         packet_class;
  logic [15:0]        ip_total_len;
  logic [5:0]         ip_header_len;
  logic [5:0]         transport_header_len;
  logic signed [16:0] payload_len;
  logic [31:0]        src_addr;
  logic [31:0]        dst_addr;
  logic [15:0]        src_port;
  logic [15:0]        dst_port;
  logic               ack_present;
  logic [31:0]        ack_number;

  modport source (
    output valid, output cap_len, output packet_class, output ip_total_len,
    output ip_header_len, output transport_header_len, output payload_len,
    output src_addr, output dst_addr, output src_port, output dst_port,
    output ack_present, output ack_number, input ready
  );
  modport sink (
    input valid, input cap_len, input packet_class, input ip_total_len,
    input ip_header_len, input transport_header_len, input payload_len,
    input src_addr, input dst_addr, input src_port, input dst_port,
    input ack_present, input ack_number, output ready
  );
endinterface

@@ src/ehp_front.sv @@
// ----------------------------------------------------------------------------
// ehp_front
// Counts frame bytes and picks header fields off the stream by byte offset.
// ----------------------------------------------------------------------------
module ehp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            push,
  output ehp_pkg::ehp_rec_t push_rec
);

  logic [15:0]       byte_count;
  logic [15:0]       byte_count_next;
  logic              oversize_seen;
  logic              oversize_next;
  ehp_pkg::ehp_hdr_t hdr;
  ehp_pkg::ehp_hdr_t hdr_next;
  logic [15:0]       l4_start;
  logic [15:0]       l4_rel;

  // saturating count and oversize flag, including this byte
  always_comb begin
    byte_count_next = (byte_count != 16'hFFFF) ? byte_count + 16'd1 : byte_count;
    oversize_next   = oversize_seen | (byte_count >= ehp_pkg::MAX_CAPTURE);
  end

  // field capture; byte index is the count before this byte
  always_comb begin
    hdr_next = hdr;
    l4_start = 16'd0;
    l4_rel   = 16'd0;
    if (accept) begin
      unique case (byte_count)
        ehp_pkg::OFF_ETYPE_HI: hdr_next.ethertype[15:8] = data_byte;
        ehp_pkg::OFF_ETYPE_LO: hdr_next.ethertype[7:0]  = data_byte;
        ehp_pkg::OFF_IHL:      hdr_next.ihl             = data_byte[3:0];
        ehp_pkg::OFF_TOT_HI:   hdr_next.tot_len[15:8]   = data_byte;
        ehp_pkg::OFF_TOT_LO:   hdr_next.tot_len[7:0]    = data_byte;
        ehp_pkg::OFF_PROTO:    hdr_next.proto           = data_byte;
        ehp_pkg::OFF_SRC0:     hdr_next.src_addr[31:24] = data_byte;
        ehp_pkg::OFF_SRC1:     hdr_next.src_addr[23:16] = data_byte;
        ehp_pkg::OFF_SRC2:     hdr_next.src_addr[15:8]  = data_byte;
        ehp_pkg::OFF_SRC3:     hdr_next.src_addr[7:0]   = data_byte;
        ehp_pkg::OFF_DST0:     hdr_next.dst_addr[31:24] = data_byte;
        ehp_pkg::OFF_DST1:     hdr_next.dst_addr[23:16] = data_byte;
        ehp_pkg::OFF_DST2:     hdr_next.dst_addr[15:8]  = data_byte;
        ehp_pkg::OFF_DST3:     hdr_next.dst_addr[7:0]   = data_byte;
        default: ;
      endcase

      // transport header sits right after ihl*4 bytes of ip header,
      // which can start at the ihl byte itself when ihl is zero
      l4_start = ehp_pkg::ETH_LEN + {10'd0, hdr_next.ihl, 2'b00};
      l4_rel   = byte_count - l4_start;
      if ((byte_count >= ehp_pkg::OFF_IHL) && (byte_count >= l4_start) &&
          (l4_rel < ehp_pkg::L4_SPAN)) begin
        unique case (l4_rel[3:0])
          ehp_pkg::L4_SPORT_HI: hdr_next.src_port[15:8] = data_byte;
          ehp_pkg::L4_SPORT_LO: hdr_next.src_port[7:0]  = data_byte;
          ehp_pkg::L4_DPORT_HI: hdr_next.dst_port[15:8] = data_byte;
          ehp_pkg::L4_DPORT_LO: hdr_next.dst_port[7:0]  = data_byte;
          ehp_pkg::L4_ULEN_HI:  hdr_next.udp_len[15:8]  = data_byte;
          ehp_pkg::L4_ULEN_LO:  hdr_next.udp_len[7:0]   = data_byte;
          ehp_pkg::L4_ACK0:     hdr_next.ack_num[31:24] = data_byte;
          ehp_pkg::L4_ACK1:     hdr_next.ack_num[23:16] = data_byte;
          ehp_pkg::L4_ACK2:     hdr_next.ack_num[15:8]  = data_byte;
          ehp_pkg::L4_ACK3:     hdr_next.ack_num[7:0]   = data_byte;
          ehp_pkg::L4_DOFF:     hdr_next.doff           = data_byte[7:4];
          ehp_pkg::L4_FLAGS:    hdr_next.ack_flag       = data_byte[4];
          default: ;
        endcase
      end
    end
  end

  // frame record goes out on the last byte transfer
  assign push             = accept & last_byte;
  assign push_rec.cap_len  = byte_count_next;
  assign push_rec.oversize = oversize_next;
  assign push_rec.hdr      = hdr_next;

  // counters, cleared at frame end
  always_ff @(posedge clk) begin
    hdr <= hdr_next;
    if (rst) begin
      byte_count    <= 16'd0;
      oversize_seen <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count    <= 16'd0;
        oversize_seen <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        oversize_seen <= oversize_next;
      end
    end
  end

endmodule

@@ src/ehp_queue.sv @@
// ----------------------------------------------------------------------------
// ehp_queue
// Two-entry queue of finished frame records between front and back.
// ----------------------------------------------------------------------------
module ehp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ehp_pkg::ehp_rec_t push_rec,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output ehp_pkg::ehp_rec_t head_rec
);

  ehp_pkg::ehp_rec_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = entries[rd_ptr];
  assign do_pop     = pop & head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ src/ehp_back.sv @@
// ----------------------------------------------------------------------------
// ehp_back
// Classifies a frame record, derives lengths and registers the result.
// ----------------------------------------------------------------------------
module ehp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  ehp_pkg::ehp_rec_t head_rec,
  output logic              pop,
  ehp_out_if.source         res
);

  ehp_pkg::ehp_class_t cls;
  logic [5:0]          ihl4;
  logic [5:0]          doff4;
  logic [16:0]         l4_start;
  logic [16:0]         cap17;
  logic                is_tcp;
  logic                is_udp;
  logic                ip_ok;
  logic                l4_ok;
  logic [15:0]         tot_r;
  logic [5:0]          ihl_r;
  logic [5:0]          thl_r;
  logic [16:0]         pay_r;
  logic [31:0]         src_r;
  logic [31:0]         dst_r;
  logic [15:0]         sport_r;
  logic [15:0]         dport_r;
  logic                ack_r;
  logic [31:0]         ackn_r;

  // classification
  always_comb begin
    ihl4     = {head_rec.hdr.ihl, 2'b00};
    doff4    = {head_rec.hdr.doff, 2'b00};
    cap17    = {1'b0, head_rec.cap_len};
    l4_start = {1'b0, ehp_pkg::ETH_LEN} + {11'd0, ihl4};
    is_tcp   = (head_rec.hdr.proto == ehp_pkg::PROTO_TCP);
    is_udp   = (head_rec.hdr.proto == ehp_pkg::PROTO_UDP);
    priority if (head_rec.oversize) begin
      cls = ehp_pkg::CLS_TOO_BIG;
    end else if (head_rec.cap_len < ehp_pkg::ETH_LEN) begin
      cls = ehp_pkg::CLS_RUNT;
    end else if (head_rec.hdr.ethertype != ehp_pkg::ETYPE_IPV4) begin
      cls = ehp_pkg::CLS_NON_IP;
    end else if (cap17 < ehp_pkg::IP_MIN_END) begin
      cls = ehp_pkg::CLS_IP_SHORT;
    end else if (is_tcp) begin
      if (cap17 < l4_start + ehp_pkg::TCP_MIN) begin
        cls = ehp_pkg::CLS_TCP_SHORT;
      end else begin
        cls = ehp_pkg::CLS_TCP;
      end
    end else if (is_udp) begin
      if (cap17 < l4_start + ehp_pkg::UDP_LEN) begin
        cls = ehp_pkg::CLS_UDP_SHORT;
      end else begin
        cls = ehp_pkg::CLS_UDP;
      end
    end else begin
      cls = ehp_pkg::CLS_IP_OTHER;
    end
    ip_ok = (cls == ehp_pkg::CLS_IP_OTHER) || (cls == ehp_pkg::CLS_TCP_SHORT) ||
            (cls == ehp_pkg::CLS_TCP) || (cls == ehp_pkg::CLS_UDP_SHORT) ||
            (cls == ehp_pkg::CLS_UDP);
    l4_ok = (cls == ehp_pkg::CLS_TCP) || (cls == ehp_pkg::CLS_UDP);
  end

  // field selection per class
  always_comb begin
    tot_r   = ip_ok ? head_rec.hdr.tot_len  : 16'd0;
    ihl_r   = ip_ok ? ihl4                  : 6'd0;
    src_r   = ip_ok ? head_rec.hdr.src_addr : 32'd0;
    dst_r   = ip_ok ? head_rec.hdr.dst_addr : 32'd0;
    sport_r = l4_ok ? head_rec.hdr.src_port : 16'd0;
    dport_r = l4_ok ? head_rec.hdr.dst_port : 16'd0;
    ack_r   = (cls == ehp_pkg::CLS_TCP) && head_rec.hdr.ack_flag;
    ackn_r  = ack_r ? head_rec.hdr.ack_num : 32'd0;
    if (cls == ehp_pkg::CLS_TCP) begin
      thl_r = doff4;
      pay_r = {1'b0, head_rec.hdr.tot_len} - {11'd0, ihl4} - {11'd0, doff4};
    end else if (cls == ehp_pkg::CLS_UDP) begin
      thl_r = ehp_pkg::UDP_LEN[5:0];
      pay_r = {1'b0, head_rec.hdr.udp_len} - ehp_pkg::UDP_LEN;
    end else begin
      thl_r = 6'd0;
      pay_r = 17'd0;
    end
  end

  // output register; takes a new record whenever the slot is free or draining
  assign pop = head_valid && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      res.cap_len              <= head_rec.cap_len;
      res.packet_class         <= cls;
      res.ip_total_len         <= tot_r;
      res.ip_header_len        <= ihl_r;
      res.transport_header_len <= thl_r;
      res.payload_len          <= pay_r;
      res.src_addr             <= src_r;
      res.dst_addr             <= dst_r;
      res.src_port             <= sport_r;
      res.dst_port             <= dport_r;
      res.ack_present          <= ack_r;
      res.ack_number           <= ackn_r;
    end
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

endmodule

@@ src/eth_ipv4_l4_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_core
// Ethernet / IPv4 / TCP-UDP header parser, one frame byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   pkt_in carries one frame byte per transfer, wire order, last_byte set on
//   the final byte. For each frame res_out gives one result transfer with the
//   captured length, a packet class and the decoded header fields.
//   Throughput: one byte per cycle while the record queue is not full; header
//   fields are picked off the stream as they pass, so no byte is read back
//   from storage. The record enters the queue on the last-byte transfer and
//   moves into the output register once that register is free or draining.
//   A two-entry record queue separates byte intake from result delivery:
//   while res_out is stalled, bytes keep flowing until two finished frames
//   wait in the queue, then pkt_in.ready drops.
//   Reset (synchronous, active high) clears the byte count, the oversize
//   flag, the queue and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser_core (
  input  logic      clk,
  input  logic      rst,
  ehp_in_if.sink    pkt_in,
  ehp_out_if.source res_out
);

  logic              accept;
  logic              push;
  ehp_pkg::ehp_rec_t push_rec;
  logic              pop;
  logic              q_full;
  logic              head_valid;
  ehp_pkg::ehp_rec_t head_rec;

  // input transfer
  assign pkt_in.ready = ~q_full;
  assign accept       = pkt_in.valid & pkt_in.ready;

  ehp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (pkt_in.data_byte),
    .last_byte (pkt_in.last_byte),
    .push      (push),
    .push_rec  (push_rec)
  );

  ehp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  ehp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .res        (res_out)
  );

endmodule

@@ src/ehp_checker.sv @@
// ----------------------------------------------------------------------------
// ehp_checker
// Port-level checks on the parser results, bound to the top level.
// ----------------------------------------------------------------------------
module ehp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] cap_len,
  input logic [3:0]  packet_class,
  input logic [15:0] src_port,
  input logic        ack_present
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packet_class) && $stable(cap_len))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // too-big frames exceed the capture limit and carry no ports
  a_big: assert property (@(posedge clk) disable iff (rst)
    out_valid && (packet_class == ehp_pkg::CLS_TOO_BIG) |->
      (cap_len > ehp_pkg::MAX_CAPTURE) && (src_port == 16'd0) && !ack_present)
    else $error("too-big result inconsistent");

  // runts are shorter than an ethernet header
  a_runt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (packet_class == ehp_pkg::CLS_RUNT) |-> cap_len < ehp_pkg::ETH_LEN)
    else $error("runt class on long frame");

  // ack only on a complete tcp header
  a_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_present |-> packet_class == ehp_pkg::CLS_TCP)
    else $error("ack flag outside tcp class");

endmodule

bind eth_ipv4_l4_header_parser_core ehp_checker u_ehp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (res_out.valid),
  .out_ready    (res_out.ready),
  .cap_len      (res_out.cap_len),
  .packet_class (res_out.packet_class),
  .src_port     (res_out.src_port),
  .ack_present  (res_out.ack_present)
);

@@ verif/ehp_parse_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehp_parse_checker
// Watches the byte and result channels of the header parser. Each byte
// transfer updates a private copy of the header store and the frame length.
// At the last byte the expected result is worked out and queued. Each result
// transfer is then compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module ehp_parse_checker (
  input  logic       clk,
  input  logic       rst,
  ehp_in_if          pkt_mon,
  ehp_out_if         res_mon,
  output int         fail_count,
  output int         pending_results,
  output int         results_checked,
  output logic [8:0] class_mask
);

  localparam int STORE_DEPTH = 128;
  localparam int FRAME_LIMIT = 1600;
  localparam int ETH_HDR     = 14;
  localparam int IP_HDR_END  = 34;
  localparam int TCP_HDR_MIN = 20;
  localparam int UDP_HDR     = 8;

  typedef struct packed {
    logic [15:0]         cap_len;
    ehp_pkg::ehp_class_t cls;
    logic [15:0]         ip_total_len;
    logic [5:0]          ip_header_len;
    logic [5:0]          l4_header_len;
    logic [16:0]         payload_len;
    logic [31:0]         src_addr;
    logic [31:0]         dst_addr;
    logic [15:0]         src_port;
    logic [15:0]         dst_port;
    logic                ack_present;
    logic [31:0]         ack_number;
  } parse_result_t;

  logic [7:0]    hdr_bytes [STORE_DEPTH];
  int unsigned   frame_len;
  logic          frame_oversize;
  parse_result_t expected_q [$];
  int            mismatches;
  int            checked;
  logic [8:0]    seen_classes;

  function automatic logic [7:0] hdr_at(input int unsigned idx);
    return (idx < STORE_DEPTH) ? hdr_bytes[idx] : 8'h00;
  endfunction

  function automatic logic [15:0] hdr16(input int unsigned idx);
    return {hdr_at(idx), hdr_at(idx + 1)};
  endfunction

  function automatic logic [31:0] hdr32(input int unsigned idx);
    return {hdr16(idx), hdr16(idx + 2)};
  endfunction

  // expected result of the frame that has just ended
  function automatic parse_result_t parse_frame();
    parse_result_t r;
    logic [7:0]    b;
    logic [7:0]    proto;
    int unsigned   ihl4;
    int unsigned   l4;
    int unsigned   doff4;
    int            pay;
    r = '0;
    pay = 0;
    r.cap_len = frame_len[15:0];
    if (frame_oversize) begin
      r.cls = ehp_pkg::CLS_TOO_BIG;
    end else if (frame_len < ETH_HDR) begin
      r.cls = ehp_pkg::CLS_RUNT;
    end else if (hdr16(12) != ehp_pkg::ETYPE_IPV4) begin
      r.cls = ehp_pkg::CLS_NON_IP;
    end else if (frame_len < IP_HDR_END) begin
      r.cls = ehp_pkg::CLS_IP_SHORT;
    end else begin
      // transport header sits right after the ip header, whatever ihl says
      b = hdr_at(ETH_HDR);
      ihl4 = b[3:0] * 4;
      l4 = ETH_HDR + ihl4;
      proto = hdr_at(ETH_HDR + 9);
      r.ip_total_len = hdr16(ETH_HDR + 2);
      r.ip_header_len = ihl4[5:0];
      r.src_addr = hdr32(ETH_HDR + 12);
      r.dst_addr = hdr32(ETH_HDR + 16);
      if (proto == ehp_pkg::PROTO_TCP) begin
        if (frame_len < l4 + TCP_HDR_MIN) begin
          r.cls = ehp_pkg::CLS_TCP_SHORT;
        end else begin
          b = hdr_at(l4 + 12);
          doff4 = b[7:4] * 4;
          r.cls = ehp_pkg::CLS_TCP;
          r.l4_header_len = doff4[5:0];
          pay = int'(r.ip_total_len) - int'(ihl4) - int'(doff4);
          r.src_port = hdr16(l4);
          r.dst_port = hdr16(l4 + 2);
          b = hdr_at(l4 + 13);
          if (b[4]) begin
            r.ack_present = 1'b1;
            r.ack_number = hdr32(l4 + 8);
          end
        end
      end else if (proto == ehp_pkg::PROTO_UDP) begin
        if (frame_len < l4 + UDP_HDR) begin
          r.cls = ehp_pkg::CLS_UDP_SHORT;
        end else begin
          r.cls = ehp_pkg::CLS_UDP;
          r.l4_header_len = 6'(UDP_HDR);
          pay = int'(hdr16(l4 + 4)) - UDP_HDR;
          r.src_port = hdr16(l4);
          r.dst_port = hdr16(l4 + 2);
        end
      end else begin
        r.cls = ehp_pkg::CLS_IP_OTHER;
      end
    end
    r.payload_len = pay[16:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    parse_result_t want;
    if (rst) begin
      frame_len = 0;
      frame_oversize = 1'b0;
      expected_q.delete();
      mismatches = 0;
      checked = 0;
      seen_classes = '0;
    end else begin
      // byte transfer: store header bytes and count the frame
      if (pkt_mon.valid && pkt_mon.ready) begin
        if (frame_len >= FRAME_LIMIT) frame_oversize = 1'b1;
        if (frame_len < STORE_DEPTH) hdr_bytes[frame_len] = pkt_mon.data_byte;
        if (frame_len < 16'hFFFF) frame_len++;
        if (pkt_mon.last_byte) begin
          expected_q.push_back(parse_frame());
          frame_len = 0;
          frame_oversize = 1'b0;
        end
      end
      // result transfer: compare with the oldest frame still owed
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("result transfer with no frame waiting for one");
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (res_mon.packet_class < 9) seen_classes[res_mon.packet_class] = 1'b1;
          compare_field("cap_len", want.cap_len, res_mon.cap_len);
          compare_field("packet_class", want.cls, res_mon.packet_class);
          compare_field("ip_total_len", want.ip_total_len, res_mon.ip_total_len);
          compare_field("ip_header_len", want.ip_header_len, res_mon.ip_header_len);
          compare_field("transport_header_len", want.l4_header_len,
                        res_mon.transport_header_len);
          compare_field("payload_len", want.payload_len,
                        $unsigned(res_mon.payload_len));
          compare_field("src_addr", want.src_addr, res_mon.src_addr);
          compare_field("dst_addr", want.dst_addr, res_mon.dst_addr);
          compare_field("src_port", want.src_port, res_mon.src_port);
          compare_field("dst_port", want.dst_port, res_mon.dst_port);
          compare_field("ack_present", want.ack_present, res_mon.ack_present);
          compare_field("ack_number", want.ack_number, res_mon.ack_number);
        end
      end
    end
    fail_count <= mismatches;
    pending_results <= expected_q.size();
    results_checked <= checked;
    class_mask <= seen_classes;
  end

endmodule

@@ verif/eth_ipv4_l4_header_parser_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_core_test
// Feeds whole frames into the header parser, byte by byte: directed frames at
// the class boundaries, then random mostly well-formed ethernet/ipv4/tcp/udp
// frames, under three idle patterns on both channels. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser_core_test;

  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int BYTES_PER_PHASE  = 360;
  localparam int FRAMES_PER_PHASE = 4;
  localparam int DRAIN_CYCLES     = 8;

  typedef enum int {
    FRM_RUNT,
    FRM_NON_IP,
    FRM_IP_SHORT,
    FRM_IP_OTHER,
    FRM_TCP_SHORT,
    FRM_TCP,
    FRM_UDP_SHORT,
    FRM_UDP,
    FRM_OVERSIZE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ehp_in_if  pkt_ch ();
  ehp_out_if res_ch ();

  int         fail_count;
  int         pending_results;
  int         results_checked;
  logic [8:0] class_mask;

  int         src_idle_pct;
  int         snk_idle_pct;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  logic [7:0] frame_buf [$];

  eth_ipv4_l4_header_parser_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_ch),
    .res_out (res_ch)
  );

  ehp_parse_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .pkt_mon         (pkt_ch),
    .res_mon         (res_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .class_mask      (class_mask)
  );

  always #4 clk = ~clk;

  // result side stalls at random
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_byte(input int idx, input logic [7:0] value);
    if (idx < frame_buf.size()) frame_buf[idx] = value;
  endtask

  task automatic put16(input int idx, input logic [15:0] value);
    put_byte(idx, value[15:8]);
    put_byte(idx + 1, value[7:0]);
  endtask

  // random frame content, then the header fields that steer the class
  task automatic make_frame(input frame_kind_t kind, input int fixed_len = -1,
                            input int ihl_sel = -1, input int doff_sel = -1);
    int          len;
    int          ihl;
    int          l4;
    int          doff;
    int          room;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ver;
    frame_buf.delete();
    // ip header length first, it places the transport header
    if (ihl_sel >= 0) ihl = ihl_sel;
    else if (kind == FRM_TCP_SHORT || kind == FRM_UDP_SHORT) ihl = $urandom_range(15, 5);
    else if ($urandom_range(3) == 0) ihl = $urandom_range(15, 0);
    else ihl = 5;
    l4 = 14 + ihl * 4;
    if (doff_sel >= 0) doff = doff_sel;
    else if ($urandom_range(7) == 0) doff = $urandom_range(15, 0);
    else doff = $urandom_range(15, 5);
    room = (doff * 4 > 20) ? doff * 4 : 20;
    case (kind)
      FRM_RUNT:      len = $urandom_range(13, 1);
      FRM_NON_IP:    len = $urandom_range(80, 14);
      FRM_IP_SHORT:  len = $urandom_range(33, 14);
      FRM_IP_OTHER:  len = $urandom_range(90, 34);
      FRM_TCP_SHORT: len = $urandom_range(l4 + 19, 34);
      FRM_TCP:       len = l4 + room + $urandom_range(40, 0);
      FRM_UDP_SHORT: len = $urandom_range(l4 + 7, 34);
      FRM_UDP:       len = l4 + 8 + $urandom_range(40, 0);
      default:       len = $urandom_range(1650, 1601);
    endcase
    if (len < 34 && kind != FRM_RUNT && kind != FRM_NON_IP && kind != FRM_IP_SHORT)
      len = 34;
    if (fixed_len > 0) len = fixed_len;
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));

    // transport fields first so that ip fields win where they overlap
    if (kind == FRM_TCP || kind == FRM_TCP_SHORT || kind == FRM_OVERSIZE)
      put_byte(l4 + 12, {4'(doff), 4'($urandom)});
    if (kind == FRM_UDP)
      put16(l4 + 4, ($urandom_range(3) == 0) ? 16'($urandom) : 16'(len - l4));

    // ethertype, with single-bit near misses for non-ip frames
    if (kind == FRM_NON_IP) begin
      if ($urandom_range(1) == 0) etype = ehp_pkg::ETYPE_IPV4 ^ (16'h1 << $urandom_range(15));
      else etype = 16'($urandom);
      if (etype == ehp_pkg::ETYPE_IPV4) etype[0] = 1'b1;
    end else begin
      etype = ehp_pkg::ETYPE_IPV4;
    end
    if (kind != FRM_RUNT) put16(12, etype);

    // ipv4 header fields
    if (kind != FRM_RUNT && kind != FRM_NON_IP) begin
      ver = ($urandom_range(7) == 0) ? 4'($urandom) : 4'h4;
      put_byte(14, {ver, 4'(ihl)});
      put16(16, ($urandom_range(1) == 0) ? 16'(len - 14) : 16'($urandom));
      if (kind == FRM_TCP || kind == FRM_TCP_SHORT || kind == FRM_OVERSIZE) begin
        proto = ehp_pkg::PROTO_TCP;
      end else if (kind == FRM_UDP || kind == FRM_UDP_SHORT) begin
        proto = ehp_pkg::PROTO_UDP;
      end else begin
        proto = 8'($urandom);
        if (proto == ehp_pkg::PROTO_TCP || proto == ehp_pkg::PROTO_UDP) proto = 8'hFF;
      end
      put_byte(23, proto);
    end
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 4) return FRM_RUNT;
    if (r < 10) return FRM_NON_IP;
    if (r < 16) return FRM_IP_SHORT;
    if (r < 24) return FRM_IP_OTHER;
    if (r < 32) return FRM_TCP_SHORT;
    if (r < 62) return FRM_TCP;
    if (r < 70) return FRM_UDP_SHORT;
    return FRM_UDP;
  endfunction

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_ch.valid     <= 1'b1;
    pkt_ch.data_byte <= value;
    pkt_ch.last_byte <= is_last;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // hold the byte side until every owed result has come out
  task automatic wait_for_results();
    pkt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int src_pct, input int snk_pct);
    int start_bytes;
    int start_frames;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start_bytes = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < BYTES_PER_PHASE ||
           frames_sent - start_frames < FRAMES_PER_PHASE) begin
      make_frame(pick_kind());
      send_frame();
    end
    wait_for_results();
  endtask

  initial begin
    pkt_ch.valid = 1'b0;
    pkt_ch.data_byte = 8'h00;
    pkt_ch.last_byte = 1'b0;
    res_ch.ready = 1'b0;
    src_idle_pct = 33;
    snk_idle_pct = 69;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // class boundaries and odd header lengths
    make_frame(FRM_RUNT, 1);            send_frame();
    make_frame(FRM_RUNT, 13);           send_frame();
    make_frame(FRM_NON_IP, 14);         send_frame();
    make_frame(FRM_IP_SHORT, 14);       send_frame();
    make_frame(FRM_IP_SHORT, 33);       send_frame();
    make_frame(FRM_IP_OTHER, 34);       send_frame();
    make_frame(FRM_TCP, 54, 5, 5);      send_frame();
    make_frame(FRM_TCP_SHORT, 53, 5);   send_frame();
    make_frame(FRM_TCP, 34, 0, 0);      send_frame();
    make_frame(FRM_TCP, 134, 15, 15);   send_frame();
    make_frame(FRM_TCP, 60, 3, 0);      send_frame();
    make_frame(FRM_UDP, 42, 5);         send_frame();
    make_frame(FRM_UDP_SHORT, 41, 5);   send_frame();
    make_frame(FRM_UDP, 34, 2);         send_frame();
    make_frame(FRM_UDP, 83, 15);        send_frame();
    wait_for_results();

    run_random_phase(33, 69);
    run_random_phase(69, 33);
    run_random_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d frame bytes in %0d frames, %0d results compared",
             bytes_sent, frames_sent, results_checked);
    $display("packet classes reached, one bit per class from too big down to runt: %b",
             class_mask);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ehp_pkg.sv
src/ehp_if.sv
src/ehp_front.sv
src/ehp_queue.sv
src/ehp_back.sv
src/eth_ipv4_l4_header_parser_core.sv
src/ehp_checker.sv
verif/ehp_parse_checker.sv
verif/eth_ipv4_l4_header_parser_core_test.sv
